// File: rtl/tkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_pkg
// Shared types, codes and helpers of the keyframe trajectory interpolator.
// ----------------------------------------------------------------------------
package tkf_pkg;

    localparam int DIV_W = 64;
    localparam int DVS_W = 32;

    localparam logic OPC_LOAD  = 1'b0;
    localparam logic OPC_QUERY = 1'b1;

    localparam logic [1:0] CFG_ACCEL_X   = 2'd0;
    localparam logic [1:0] CFG_ACCEL_Y   = 2'd1;
    localparam logic [1:0] CFG_ACCEL_Z   = 2'd2;
    localparam logic [1:0] CFG_SEG_COUNT = 2'd3;

    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_PAST   = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END,
        S_CHK,
        S_WALK,
        S_PREV,
        S_ST,
        S_EN,
        S_DSTART,
        S_DIV,
        S_MHI,
        S_MLO,
        S_MSUM,
        S_OP
    } t_state;

    typedef enum logic [2:0] {
        MOP_VDIV,
        MOP_VACC,
        MOP_W,
        MOP_PV,
        MOP_PW,
        MOP_FDIV,
        MOP_ANG
    } t_mop;

    typedef struct packed {
        logic [31:0]      tm;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] ang;
    } t_key;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } t_mdiff;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat;

    function automatic t_mdiff mag_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] m;
        t_mdiff      r;
        d     = {a[31], a} - {b[31], b};
        m     = d[32] ? (~d + 33'd1) : d;
        r.neg = d[32];
        r.mag = m[31:0];
        return r;
    endfunction

    function automatic t_sat sat32(input logic [63:0] x);
        t_sat r;
        r.ovf = 1'b0;
        r.val = x[31:0];
        if (!x[63] && (x[62:31] != '0)) begin
            r.ovf = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (x[63] && (x[62:31] != '1)) begin
            r.ovf = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

endpackage

// File: rtl/accel_tumble_keyframe_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tumble_keyframe_interp
// Keyframe table with constant-acceleration position and linear angle
// interpolation, computed by one shared 32x32 multiplier and one divider.
// ----------------------------------------------------------------------------
// A load returns nothing. A query walks the table in the segment search; a
// query past the last keyframe returns right after the end-key check, and a
// zero-length segment returns once both segment keys are read. A full query
// runs the radix-2 divider four times (three velocities and the angle
// fraction) and uses the shared multiplier, two half-width passes for each
// product, four products per axis and one per angle. busy stays high for
// the whole query; the result appears for one cycle on o_strobe and cannot be
// held off, so the receiver must capture it then.
module accel_tumble_keyframe_interp #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_opcode,
    input  logic [6:0]  i_entry_index,
    input  logic [31:0] i_time_value,
    input  logic signed [31:0] i_in_pos_x,
    input  logic signed [31:0] i_in_pos_y,
    input  logic signed [31:0] i_in_pos_z,
    input  logic signed [31:0] i_in_azimuth,
    input  logic signed [31:0] i_in_elevation,
    input  logic signed [31:0] i_in_roll,
    output logic        o_strobe,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_out_azimuth,
    output logic signed [31:0] o_out_elevation,
    output logic signed [31:0] o_out_roll,
    output logic [1:0]  o_status
);
    import tkf_pkg::*;

    localparam int          KEYS  = MAX_SEGMENTS + 1;
    localparam int          IDX_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [31:0] MAX_W = 32'(MAX_SEGMENTS);

    t_key                r_mem [KEYS];

    t_state              r_state, n_state;
    t_mop                r_op, n_op;
    logic [1:0]          r_axis, n_axis;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_n, n_n;
    logic [IDX_W-1:0]    r_cseg, n_cseg;
    logic                r_cvalid, n_cvalid;
    logic [31:0]         r_t, n_t;
    t_key                r_row, r_k0, n_k0, r_k1, n_k1;
    logic [31:0]         r_seg_t, n_seg_t;
    logic [31:0]         r_ts, n_ts;
    logic [63:0]         r_qd, n_qd;
    logic [31:0]         r_v, n_v;
    logic [47:0]         r_wm, n_wm;
    logic                r_ws, n_ws;
    logic [63:0]         r_pv, n_pv;
    logic [31:0]         r_ha, n_ha, r_hb, n_hb, r_la, n_la, r_lb, n_lb;
    logic                r_ang, n_ang;
    logic [63:0]         r_prod, r_acc, n_acc;
    logic                r_sat, n_sat;
    logic [2:0][31:0]    r_accel;
    logic [6:0]          r_seg_count;
    logic [2:0][31:0]    r_o_pos, n_o_pos, r_o_ang, n_o_ang;
    logic [1:0]          r_status, n_status;
    logic                r_strobe, n_strobe;

    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    n_eff;
    logic [31:0]         seg_w;
    logic                accept, wr_ok;
    t_key                wr_row;
    logic                end_lt, can_walk;
    logic [31:0]         start_tm, seg_t, seg_ts;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic                div_start, div_done;
    logic [63:0]         div_dvd, div_quot;
    logic [1:0]          nx_axis;
    logic [31:0]         cur_a, a_mag, v_mag;
    logic                a_neg;
    t_mdiff              dpos, dang, dang_nx;
    logic [63:0]         half_acc, sub_v, pw_v, q_ang;
    t_sat                v_sat, p_sat, ang_sat;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign seg_w = {25'd0, r_seg_count};
    always_comb begin
        if (seg_w == 32'd0) begin
            n_eff = IDX_W'(1);
        end else if (seg_w > MAX_W) begin
            n_eff = IDX_W'(MAX_SEGMENTS);
        end else begin
            n_eff = IDX_W'(seg_w);
        end
    end

    assign wr_ok  = ({25'd0, i_entry_index} <= MAX_W);
    assign wr_row = '{tm: i_time_value,
                      pos: {i_in_pos_z, i_in_pos_y, i_in_pos_x},
                      ang: {i_in_roll, i_in_elevation, i_in_azimuth}};

    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OPC_LOAD) && wr_ok) begin
            r_mem[IDX_W'(i_entry_index)] <= wr_row;
        end
        r_row <= r_mem[rd_addr];
    end

    assign end_lt   = r_row.tm < r_t;
    assign can_walk = (r_idx < (r_n - IDX_W'(1))) && end_lt;

    assign start_tm = (r_idx == '0) ? 32'd0 : r_k0.tm;
    assign seg_t    = r_row.tm - start_tm;
    assign seg_ts   = r_t - start_tm;

    assign mul_a = (r_state == S_MHI) ? r_ha : r_la;
    assign mul_b = (r_state == S_MHI) ? r_hb : r_lb;
    assign mul_p = mul_a * mul_b;

    assign nx_axis  = (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
    assign cur_a    = r_accel[r_axis];
    assign a_neg    = cur_a[31];
    assign a_mag    = a_neg ? (~cur_a + 32'd1) : cur_a;
    assign v_mag    = r_v[31] ? (~r_v + 32'd1) : r_v;
    assign dpos     = mag_diff(r_k1.pos[r_axis], r_k0.pos[r_axis]);
    assign dang     = mag_diff(r_k1.ang[r_axis], r_k0.ang[r_axis]);
    assign dang_nx  = mag_diff(r_k1.ang[nx_axis], r_k0.ang[nx_axis]);
    assign half_acc = {1'b0, r_acc[63:1]};
    assign sub_v    = a_neg ? (~half_acc + 64'd1) : half_acc;
    assign pw_v     = r_ws ? (~half_acc + 64'd1) : half_acc;
    assign q_ang    = {30'd0, r_acc[63:30]};
    assign v_sat    = sat32(r_qd - sub_v);
    assign p_sat    = sat32({{32{r_k0.pos[r_axis][31]}}, r_k0.pos[r_axis]} + r_pv + pw_v);
    assign ang_sat  = sat32({{32{r_k0.ang[r_axis][31]}}, r_k0.ang[r_axis]}
                            + (dang.neg ? (~q_ang + 64'd1) : q_ang));

    assign div_dvd = (r_op == MOP_VDIV) ? {16'd0, dpos.mag, 16'd0} : {2'd0, r_ts, 30'd0};

    tkf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_seg_t),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept && (i_opcode == OPC_QUERY)) n_state = S_END;
            S_END:    n_state = (r_t >= r_row.tm) ? S_IDLE : S_CHK;
            S_CHK: begin
                if (end_lt) begin
                    n_state = can_walk ? S_WALK : S_ST;
                end else if (r_idx != '0) begin
                    n_state = S_PREV;
                end else begin
                    n_state = S_ST;
                end
            end
            S_WALK:   n_state = can_walk ? S_WALK : S_ST;
            S_PREV:   n_state = (r_t < r_row.tm) ? S_WALK : S_ST;
            S_ST:     n_state = S_EN;
            S_EN:     n_state = (seg_t == 32'd0) ? S_IDLE : S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    n_state = div_done ? S_OP : S_DIV;
            S_MHI:    n_state = S_MLO;
            S_MLO:    n_state = S_MSUM;
            S_MSUM:   n_state = S_OP;
            S_OP: begin
                case (r_op)
                    MOP_PW:  n_state = S_DSTART;
                    MOP_ANG: n_state = (r_axis == 2'd2) ? S_IDLE : S_MHI;
                    default: n_state = S_MHI;
                endcase
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_addr   = r_idx;
        div_start = 1'b0;
        n_op      = r_op;
        n_axis    = r_axis;
        n_idx     = r_idx;
        n_n       = r_n;
        n_cseg    = r_cseg;
        n_cvalid  = r_cvalid;
        n_t       = r_t;
        n_k0      = r_k0;
        n_k1      = r_k1;
        n_seg_t   = r_seg_t;
        n_ts      = r_ts;
        n_qd      = r_qd;
        n_v       = r_v;
        n_wm      = r_wm;
        n_ws      = r_ws;
        n_pv      = r_pv;
        n_ha      = r_ha;
        n_hb      = r_hb;
        n_la      = r_la;
        n_lb      = r_lb;
        n_ang     = r_ang;
        n_acc     = r_acc;
        n_sat     = r_sat;
        n_o_pos   = r_o_pos;
        n_o_ang   = r_o_ang;
        n_status  = r_status;
        n_strobe  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = n_eff;
                if (accept) begin
                    if (i_opcode == OPC_LOAD) begin
                        n_cvalid = 1'b0;
                    end else begin
                        n_t = i_time_value;
                        n_n = n_eff;
                    end
                end
            end
            S_END: begin
                if (r_t >= r_row.tm) begin
                    n_o_pos  = r_row.pos;
                    n_o_ang  = r_row.ang;
                    n_status = ST_PAST;
                    n_strobe = 1'b1;
                end else begin
                    n_idx   = (r_cvalid && (r_cseg < r_n)) ? r_cseg : '0;
                    rd_addr = n_idx + IDX_W'(1);
                end
            end
            S_CHK, S_WALK: begin
                if (can_walk) begin
                    n_idx   = r_idx + IDX_W'(1);
                    rd_addr = r_idx + IDX_W'(2);
                end
            end
            S_PREV: begin
                if (r_t < r_row.tm) begin
                    n_idx   = '0;
                    rd_addr = IDX_W'(1);
                end
            end
            S_ST: begin
                n_k0     = r_row;
                n_cseg   = r_idx;
                n_cvalid = 1'b1;
                rd_addr  = r_idx + IDX_W'(1);
            end
            S_EN: begin
                n_k1    = r_row;
                n_seg_t = seg_t;
                n_ts    = seg_ts;
                n_op    = MOP_VDIV;
                n_axis  = 2'd0;
                n_sat   = 1'b0;
                if (seg_t == 32'd0) begin
                    n_o_pos  = r_row.pos;
                    n_o_ang  = r_row.ang;
                    n_status = ST_ZERO;
                    n_strobe = 1'b1;
                end
            end
            S_DSTART: div_start = 1'b1;
            S_DIV, S_MHI: begin
            end
            S_MLO:  n_acc = r_ang ? {r_prod[31:0], 32'd0} : r_prod;
            S_MSUM: n_acc = r_acc + (r_ang ? r_prod : {16'd0, r_prod[63:16]});
            S_OP: begin
                n_ang = 1'b0;
                n_hb  = r_ts;
                n_lb  = r_ts;
                case (r_op)
                    MOP_VDIV: begin
                        n_qd = dpos.neg ? (~div_quot + 64'd1) : div_quot;
                        n_ha = {16'd0, a_mag[31:16]};
                        n_la = {16'd0, a_mag[15:0]};
                        n_hb = r_seg_t;
                        n_lb = r_seg_t;
                        n_op = MOP_VACC;
                    end
                    MOP_VACC: begin
                        n_v   = v_sat.val;
                        n_sat = r_sat | v_sat.ovf;
                        n_ha  = {16'd0, a_mag[31:16]};
                        n_la  = {16'd0, a_mag[15:0]};
                        n_op  = MOP_W;
                    end
                    MOP_W: begin
                        n_wm = r_acc[47:0];
                        n_ws = a_neg;
                        n_ha = {16'd0, v_mag[31:16]};
                        n_la = {16'd0, v_mag[15:0]};
                        n_op = MOP_PV;
                    end
                    MOP_PV: begin
                        n_pv = r_v[31] ? (~r_acc + 64'd1) : r_acc;
                        n_ha = r_wm[47:16];
                        n_la = {16'd0, r_wm[15:0]};
                        n_op = MOP_PW;
                    end
                    MOP_PW: begin
                        n_o_pos[r_axis] = p_sat.val;
                        n_sat           = r_sat | p_sat.ovf;
                        if (r_axis == 2'd2) begin
                            n_axis = 2'd0;
                            n_op   = MOP_FDIV;
                        end else begin
                            n_axis = nx_axis;
                            n_op   = MOP_VDIV;
                        end
                    end
                    MOP_FDIV: begin
                        n_ang = 1'b1;
                        n_ha  = dang.mag;
                        n_la  = dang.mag;
                        n_hb  = {2'd0, div_quot[61:32]};
                        n_lb  = div_quot[31:0];
                        n_op  = MOP_ANG;
                    end
                    MOP_ANG: begin
                        n_ang           = 1'b1;
                        n_hb            = r_hb;
                        n_lb            = r_lb;
                        n_ha            = dang_nx.mag;
                        n_la            = dang_nx.mag;
                        n_o_ang[r_axis] = ang_sat.val;
                        n_sat           = r_sat | ang_sat.ovf;
                        n_axis          = nx_axis;
                        if (r_axis == 2'd2) begin
                            n_status = (r_sat || ang_sat.ovf) ? ST_SAT : ST_INSIDE;
                            n_strobe = 1'b1;
                        end
                    end
                    default: n_op = MOP_VDIV;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_strobe    <= 1'b0;
            r_cvalid    <= 1'b0;
            r_cseg      <= '0;
            r_accel     <= '0;
            r_seg_count <= 7'd1;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cseg   <= n_cseg;
            r_cvalid <= i_cfg_we ? 1'b0 : n_cvalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx) inside
                    CFG_ACCEL_X, CFG_ACCEL_Y, CFG_ACCEL_Z: r_accel[i_cfg_idx] <= i_cfg_data;
                    CFG_SEG_COUNT: r_seg_count <= i_cfg_data[6:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_axis   <= n_axis;
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_t      <= n_t;
        r_k0     <= n_k0;
        r_k1     <= n_k1;
        r_seg_t  <= n_seg_t;
        r_ts     <= n_ts;
        r_qd     <= n_qd;
        r_v      <= n_v;
        r_wm     <= n_wm;
        r_ws     <= n_ws;
        r_pv     <= n_pv;
        r_ha     <= n_ha;
        r_hb     <= n_hb;
        r_la     <= n_la;
        r_lb     <= n_lb;
        r_ang    <= n_ang;
        r_prod   <= mul_p;
        r_acc    <= n_acc;
        r_sat    <= n_sat;
        r_o_pos  <= n_o_pos;
        r_o_ang  <= n_o_ang;
        r_status <= n_status;
    end

    assign o_strobe        = r_strobe;
    assign o_out_pos_x     = r_o_pos[0];
    assign o_out_pos_y     = r_o_pos[1];
    assign o_out_pos_z     = r_o_pos[2];
    assign o_out_azimuth   = r_o_ang[0];
    assign o_out_elevation = r_o_ang[1];
    assign o_out_roll      = r_o_ang[2];
    assign o_status        = r_status;

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while still busy");

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_cache_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cvalid |-> ({{(32 - IDX_W){1'b0}}, r_cseg} < MAX_W))
        else $error("cached segment out of range");

endmodule

// File: rtl/tkf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkf_div
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tkf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tkf_pkg::DIV_W-1:0]  i_dividend,
    input  logic [tkf_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [tkf_pkg::DIV_W-1:0]  o_quot
);
    import tkf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DIV_W-1:0]   r_q, n_q;
    logic [DVS_W-1:0]   r_rem, n_rem;
    logic [DVS_W-1:0]   r_dvs, n_dvs;
    logic [DVS_W:0]     trial;
    logic               ge;

    assign trial = {r_rem, r_q[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_W);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
            n_q   = {r_q[DIV_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyframe trajectory interpolator. Keyframe
// tables are loaded and queried in phases under changing acceleration and
// segment settings. A predictor computes each expected pose and status, and
// a monitor compares every strobed result with the oldest pending pose.
// ----------------------------------------------------------------------------
module tb;
    import tkf_pkg::*;

    localparam int KEYS      = 65;
    localparam int MAX_SEG   = 64;
    localparam int SETTLE    = 400;
    localparam int WDOG_LIM  = 5000;

    typedef struct packed {
        logic             op;
        logic [6:0]       slot;
        logic [31:0]      tm;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] ang;
    } t_item;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] ang;
        logic [1:0]       st;
    } t_pose;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_strobe;
    logic signed [31:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [31:0] o_out_azimuth, o_out_elevation, o_out_roll;
    logic [1:0]  o_status;

    t_item cur_item = '0;
    t_item pending_items[$];
    t_pose expected_poses[$];

    // predictor state
    bit [31:0] key_tm[KEYS];
    int        key_pos[KEYS][3];
    int        key_ang[KEYS][3];
    int        accel[3];
    bit [6:0]  seg_count;
    int        cache_seg;
    bit        cache_ok;
    bit        sat_hit;

    bit [31:0] ktab[KEYS];
    int        items_sent;
    int        errors;
    int        gap_left;
    int        gap;
    bit        no_idle;
    int        idle_cycles;

    accel_tumble_keyframe_interp u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (cur_item.op),
        .i_entry_index   (cur_item.slot),
        .i_time_value    (cur_item.tm),
        .i_in_pos_x      (cur_item.pos[0]),
        .i_in_pos_y      (cur_item.pos[1]),
        .i_in_pos_z      (cur_item.pos[2]),
        .i_in_azimuth    (cur_item.ang[0]),
        .i_in_elevation  (cur_item.ang[1]),
        .i_in_roll       (cur_item.ang[2]),
        .o_strobe        (o_strobe),
        .o_out_pos_x     (o_out_pos_x),
        .o_out_pos_y     (o_out_pos_y),
        .o_out_pos_z     (o_out_pos_z),
        .o_out_azimuth   (o_out_azimuth),
        .o_out_elevation (o_out_elevation),
        .o_out_roll      (o_out_roll),
        .o_status        (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint mul_q16(input longint x, input bit [31:0] t);
        longint unsigned m;
        longint unsigned r;
        m = (x < 0) ? -x : x;
        r = (m >> 16) * t + (((m & 64'hFFFF) * t) >> 16);
        return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic int clip32(input longint x);
        if (x > 64'sd2147483647) begin
            sat_hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            sat_hit = 1'b1;
            return 32'h8000_0000;
        end
        return int'(x);
    endfunction

    function automatic t_pose keyframe_pose(input int k, input logic [1:0] st);
        t_pose r;
        for (int j = 0; j < 3; j++) begin
            r.pos[j] = key_pos[k][j];
            r.ang[j] = key_ang[k][j];
        end
        r.st = st;
        return r;
    endfunction

    function automatic void predict_pose(input t_item it);
        t_pose           r;
        int              n;
        int              idx;
        bit [31:0]       t;
        bit [31:0]       seg_t0;
        bit [31:0]       span;
        bit [31:0]       ts;
        longint          p0, d, v, w, p, r0, delta;
        longint unsigned f, m, q;
        if (it.op == OPC_LOAD) begin
            if (it.slot <= MAX_SEG) begin
                key_tm[it.slot] = it.tm;
                for (int j = 0; j < 3; j++) begin
                    key_pos[it.slot][j] = it.pos[j];
                    key_ang[it.slot][j] = it.ang[j];
                end
            end
            cache_ok = 1'b0;
            return;
        end
        t = it.tm;
        n = seg_count;
        if (n < 1) n = 1;
        if (n > MAX_SEG) n = MAX_SEG;
        if (t >= key_tm[n]) begin
            expected_poses.push_back(keyframe_pose(n, ST_PAST));
            return;
        end
        idx = cache_seg;
        if (!cache_ok || idx >= n) idx = 0;
        if (key_tm[idx + 1] < t) begin
            while (idx < n - 1 && key_tm[idx + 1] < t) idx++;
        end else if (idx != 0 && t < key_tm[idx]) begin
            idx = 0;
            while (idx < n - 1 && key_tm[idx + 1] < t) idx++;
        end
        cache_seg = idx;
        cache_ok  = 1'b1;
        seg_t0 = (idx == 0) ? 32'd0 : key_tm[idx];
        span   = key_tm[idx + 1] - seg_t0;
        ts     = t - seg_t0;
        if (span == 0) begin
            expected_poses.push_back(keyframe_pose(idx + 1, ST_ZERO));
            return;
        end
        sat_hit = 1'b0;
        for (int j = 0; j < 3; j++) begin
            p0 = key_pos[idx][j];
            d  = longint'(key_pos[idx + 1][j]) - p0;
            v  = (d * 65536) / longint'({32'd0, span}) - mul_q16(accel[j], span) / 2;
            v  = clip32(v);
            w  = mul_q16(accel[j], ts);
            p  = p0 + mul_q16(v, ts) + mul_q16(w, ts) / 2;
            r.pos[j] = clip32(p);
        end
        f = ({32'd0, ts} << 30) / {32'd0, span};
        for (int j = 0; j < 3; j++) begin
            r0    = key_ang[idx][j];
            delta = longint'(key_ang[idx + 1][j]) - r0;
            m     = (delta < 0) ? -delta : delta;
            q     = (m * f) >> 30;
            r.ang[j] = clip32(r0 + ((delta < 0) ? -longint'(q) : longint'(q)));
        end
        r.st = sat_hit ? ST_SAT : ST_INSIDE;
        expected_poses.push_back(r);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            predict_pose(cur_item);
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap == 0 && pending_items.size() > 0) begin
                cur_item <= pending_items.pop_front();
            end else begin
                start    <= 1'b0;
                gap_left <= gap;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                cur_item <= pending_items.pop_front();
                start    <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && o_strobe) begin
            if (expected_poses.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = expected_poses.pop_front();
                check_field("out_pos_x", e.pos[0], o_out_pos_x);
                check_field("out_pos_y", e.pos[1], o_out_pos_y);
                check_field("out_pos_z", e.pos[2], o_out_pos_z);
                check_field("out_azimuth", e.ang[0], o_out_azimuth);
                check_field("out_elevation", e.ang[1], o_out_elevation);
                check_field("out_roll", e.ang[2], o_out_roll);
                check_field("status", {30'd0, e.st}, {30'd0, o_status});
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIM) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_load(input logic [6:0] slot, input logic [31:0] tm,
                             input logic [2:0][31:0] pos, input logic [2:0][31:0] ang);
        t_item it;
        it.op   = OPC_LOAD;
        it.slot = slot;
        it.tm   = tm;
        it.pos  = pos;
        it.ang  = ang;
        pending_items.push_back(it);
        if (slot <= MAX_SEG) begin
            ktab[slot] = tm;
        end
        items_sent++;
    endtask

    task automatic push_query(input logic [31:0] tm);
        t_item it;
        it      = '0;
        it.op   = OPC_QUERY;
        it.slot = 7'($urandom);
        it.tm   = tm;
        it.pos  = {$urandom, $urandom, $urandom};
        it.ang  = {$urandom, $urandom, $urandom};
        pending_items.push_back(it);
        items_sent++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'd0;
            default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
    endfunction

    function automatic logic [2:0][31:0] rand_triple();
        return {rand_coord(), rand_coord(), rand_coord()};
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || start || expected_poses.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ACCEL_X:   accel[0] = data;
            CFG_ACCEL_Y:   accel[1] = data;
            CFG_ACCEL_Z:   accel[2] = data;
            CFG_SEG_COUNT: seg_count = data[6:0];
        endcase
        cache_ok = 1'b0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_accel();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // load keyframes 0..nk with non-decreasing or scrambled times
    task automatic load_table(input int nk, input bit ordered);
        longint acc_t;
        longint step;
        acc_t = $urandom_range(0, 32'h0004_0000);
        for (int k = 0; k <= nk; k++) begin
            if (ordered) begin
                case ($urandom_range(0, 9))
                    0: step = 0;
                    1: step = $urandom_range(1, 4);
                    2: step = $urandom;
                    default: step = (longint'($urandom_range(1, 40)) << 16)
                                    + $urandom_range(0, 65535);
                endcase
                if (k > 0) acc_t = acc_t + step;
                if (acc_t > 64'hFFFF_FFFF) acc_t = 64'hFFFF_FFFF;
                push_load(7'(k), acc_t[31:0], rand_triple(), rand_triple());
            end else begin
                push_load(7'(k), $urandom_range(0, 32'h0100_0000), rand_triple(),
                          rand_triple());
            end
        end
    endtask

    task automatic run_phase();
        int     nk;
        int     nq;
        longint last_t;
        longint qt;
        logic [6:0] cnt;
        case ($urandom_range(0, 9))
            0: cnt = 7'd64;
            1: cnt = 7'd0;
            2: cnt = 7'($urandom_range(65, 127));
            default: cnt = 7'($urandom_range(1, 12));
        endcase
        cfg_write(CFG_ACCEL_X, rand_accel());
        cfg_write(CFG_ACCEL_Y, rand_accel());
        cfg_write(CFG_ACCEL_Z, rand_accel());
        cfg_write(CFG_SEG_COUNT, {25'($urandom), cnt});
        nk = (cnt == 0) ? 1 : (cnt > MAX_SEG) ? MAX_SEG : cnt;
        no_idle = ($urandom_range(0, 3) == 0);
        load_table(nk, $urandom_range(0, 5) != 0);
        last_t = ktab[nk];
        nq = $urandom_range(30, 60);
        qt = 0;
        for (int i = 0; i < nq; i++) begin
            case ($urandom_range(0, 9))
                0: push_query(ktab[$urandom_range(1, nk)]);
                1: push_query($urandom);
                2: push_query(32'd0);
                3, 4, 5: begin
                    qt = qt + $urandom_range(0, last_t / 8 + 1);
                    push_query(qt > last_t ? last_t[31:0] : qt[31:0]);
                end
                6: push_load(7'($urandom_range(65, 127)), $urandom, rand_triple(),
                             rand_triple());
                default: push_query($urandom_range(0, last_t + last_t / 8 > 64'hFFFF_FFFF
                                                   ? 32'hFFFF_FFFF : last_t + last_t / 8));
            endcase
        end
        wait_idle();
    endtask

    initial begin
        logic [2:0][31:0] zero3;
        zero3 = '0;
        items_sent = 0;
        no_idle = 1'b0;
        seg_count = 7'd1;
        cache_seg = 0;
        cache_ok = 1'b0;
        for (int j = 0; j < 3; j++) accel[j] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every slot so no later query reads an unwritten entry
        load_table(MAX_SEG, 1'b1);
        wait_idle();

        // directed: zero-length first segment, boundaries, extremes
        cfg_write(CFG_SEG_COUNT, 32'd4);
        push_load(0, 32'd0, zero3, zero3);
        push_load(1, 32'd0, {32'd100, 32'h7FFF_FFFF, 32'h8000_0000},
                  {32'h7FFF_FFFF, 32'h8000_0000, 32'd0});
        push_load(2, 32'h000A_0000, {32'h8000_0000, 32'h7FFF_FFFF, 32'd5},
                  {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
        push_load(3, 32'h0014_0000, rand_triple(), rand_triple());
        push_load(4, 32'hFFFF_FFFE, rand_triple(), rand_triple());
        push_load(100, 32'hFFFF_FFFF, {3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}});
        push_query(32'd0);
        push_query(32'h0005_0000);
        push_query(32'h000A_0000);
        push_query(32'h0014_0000);
        push_query(32'h0001_0000);
        push_query(32'hFFFF_FFFE);
        push_query(32'hFFFF_FFFF);
        push_query(32'h8000_0000);
        wait_idle();
        cfg_write(CFG_ACCEL_X, 32'h7FFF_FFFF);
        cfg_write(CFG_ACCEL_Y, 32'h8000_0000);
        cfg_write(CFG_ACCEL_Z, 32'hFFFF_FFFF);
        push_query(32'h0007_8000);
        push_query(32'h0012_0000);
        push_query(32'h7FFF_FFFF);
        wait_idle();

        while (items_sent < 950) run_phase();

        wait_idle();
        if (errors == 0 && expected_poses.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
